>>> hdl/cartridge_bank_controller_macros.svh
// Assertion macros shared by the checker of the cartridge bank controller.
`ifndef CARTRIDGE_BANK_CONTROLLER_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cbc_pkg.sv
// Package of the cartridge bank controller: widths, codes and shared types.
package cbc_pkg;

    localparam int ROM_BANK_BYTES = 16384;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int MAX_ROM_BANKS  = 512;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int ROM_BANK_W = $clog2(MAX_ROM_BANKS);
    localparam int RAM_BANK_W = 4;
    localparam int RTC_SEL_W  = 4;
    localparam int RTC_IDX_W  = 3;
    localparam int PHYS_W     = 23;
    localparam int TGT_W      = 3;
    localparam int CTYPE_W    = 3;
    localparam int ROM_CNT_W  = 10;
    localparam int RAM_CNT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int ROM_OFS_W  = $clog2(ROM_BANK_BYTES);
    localparam int RAM_OFS_W  = $clog2(RAM_BANK_BYTES);

    // Controller types.
    localparam logic [CTYPE_W-1:0] CT_NONE   = 3'd0;
    localparam logic [CTYPE_W-1:0] CT_MBC1   = 3'd1;
    localparam logic [CTYPE_W-1:0] CT_MBC2   = 3'd2;
    localparam logic [CTYPE_W-1:0] CT_MBC3   = 3'd3;
    localparam logic [CTYPE_W-1:0] CT_MBC5   = 3'd4;
    localparam logic [CTYPE_W-1:0] CT_MBC5_R = 3'd5;
    localparam logic [CTYPE_W-1:0] CT_HUC1   = 3'd6;
    localparam logic [CTYPE_W-1:0] CT_HUC3   = 3'd7;

    // Result targets.
    localparam logic [TGT_W-1:0] TGT_NONE   = 3'd0;
    localparam logic [TGT_W-1:0] TGT_ROM    = 3'd1;
    localparam logic [TGT_W-1:0] TGT_RAM    = 3'd2;
    localparam logic [TGT_W-1:0] TGT_RTC    = 3'd3;
    localparam logic [TGT_W-1:0] TGT_FIXED  = 3'd4;
    localparam logic [TGT_W-1:0] TGT_ABSORB = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_COUNT = 2'd2;

    // Control write regions, address bits 14..13 (MBC1, MBC3 and the HuC parts).
    localparam logic [1:0] RGN_ENABLE = 2'd0;
    localparam logic [1:0] RGN_ROM    = 2'd1;
    localparam logic [1:0] RGN_UPPER  = 2'd2;
    localparam logic [1:0] RGN_LATCH  = 2'd3;

    // MBC5 control regions, address bits 14..12.
    localparam logic [2:0] M5_EN_A   = 3'd0;
    localparam logic [2:0] M5_EN_B   = 3'd1;
    localparam logic [2:0] M5_ROM_LO = 3'd2;
    localparam logic [2:0] M5_ROM_HI = 3'd3;
    localparam logic [2:0] M5_RAM_A  = 3'd4;
    localparam logic [2:0] M5_RAM_B  = 3'd5;

    localparam logic [3:0]            RAM_EN_KEY     = 4'hA;
    localparam logic [DATA_W-1:0]     FIXED_HUC3     = 8'h01;
    localparam logic [DATA_W-1:0]     FIXED_OPEN     = 8'hFF;
    localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = 9'd1;
    localparam logic [2:0]            RAM_WINDOW     = 3'b101;

    typedef struct packed {
        logic [CTYPE_W-1:0]    ctrl_type;
        logic [ROM_BANK_W-1:0] rom_mask;
        logic [RAM_BANK_W-1:0] ram_mask;
    } cfg_t;

    typedef struct packed {
        logic                  mode;
        logic [ADDR_W-1:0]     bus_address;
        logic [DATA_W-1:0]     write_data;
    } req_t;

    typedef struct packed {
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  ram_enable;
        logic                  banking_mode;
        logic [RTC_SEL_W-1:0]  rtc_select;
    } bank_state_t;

    typedef struct packed {
        logic [TGT_W-1:0]      target;
        logic [PHYS_W-1:0]     physical_address;
        logic [RTC_IDX_W-1:0]  rtc_index;
        logic [DATA_W-1:0]     fixed_value;
        logic [ROM_BANK_W-1:0] rom_bank_now;
        logic [RAM_BANK_W-1:0] ram_bank_now;
        logic                  ram_enabled_now;
        logic [RTC_SEL_W-1:0]  rtc_select_now;
        logic                  latch_strobe;
        logic [DATA_W-1:0]     latch_data;
    } res_t;

endpackage

>>> hdl/cbc_ifs.sv
// Channel interfaces of the cartridge bank controller: access, result and configuration.
interface cbc_access_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [cbc_pkg::ADDR_W-1:0]    bus_address;
    logic [cbc_pkg::DATA_W-1:0]    write_data;

    modport source (output valid, mode, bus_address, write_data, input ready);
    modport sink   (input valid, mode, bus_address, write_data, output ready);
endinterface

interface cbc_result_if;
    logic                            valid;
    logic                            ready;
    logic [cbc_pkg::TGT_W-1:0]       target;
    logic [cbc_pkg::PHYS_W-1:0]      physical_address;
    logic [cbc_pkg::RTC_IDX_W-1:0]   rtc_index;
    logic [cbc_pkg::DATA_W-1:0]      fixed_value;
    logic [cbc_pkg::ROM_BANK_W-1:0]  rom_bank_now;
    logic [cbc_pkg::RAM_BANK_W-1:0]  ram_bank_now;
    logic                            ram_enabled_now;
    logic [cbc_pkg::RTC_SEL_W-1:0]   rtc_select_now;
    logic                            latch_strobe;
    logic [cbc_pkg::DATA_W-1:0]      latch_data;

    modport source (output valid, target, physical_address, rtc_index, fixed_value,
                    rom_bank_now, ram_bank_now, ram_enabled_now, rtc_select_now,
                    latch_strobe, latch_data, input ready);
    modport sink   (input valid, target, physical_address, rtc_index, fixed_value,
                    rom_bank_now, ram_bank_now, ram_enabled_now, rtc_select_now,
                    latch_strobe, latch_data, output ready);
endinterface

interface cbc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cbc_pkg::CFG_IDX_W-1:0]     index;
    logic [cbc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/cbc_cfg_regs.sv
// Configuration registers of the cartridge bank controller and the bank masks derived from them.
module cbc_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    cbc_cfg_if.sink       cfg,
    output cbc_pkg::cfg_t cfg_out
);

    logic [cbc_pkg::CTYPE_W-1:0]   ctrl_type_reg;
    logic [cbc_pkg::ROM_CNT_W-1:0] rom_count_reg;
    logic [cbc_pkg::RAM_CNT_W-1:0] ram_count_reg;
    logic [cbc_pkg::ROM_CNT_W-1:0] rom_count_m1;
    logic [cbc_pkg::RAM_CNT_W-1:0] ram_count_m1;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_type_reg <= cbc_pkg::CT_NONE;
            rom_count_reg <= cbc_pkg::ROM_CNT_W'(2);
            ram_count_reg <= cbc_pkg::RAM_CNT_W'(1);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                cbc_pkg::CFG_CTRL_TYPE: ctrl_type_reg <= cfg.data[cbc_pkg::CTYPE_W-1:0];
                cbc_pkg::CFG_ROM_COUNT: rom_count_reg <= cfg.data[cbc_pkg::ROM_CNT_W-1:0];
                cbc_pkg::CFG_RAM_COUNT: ram_count_reg <= cfg.data[cbc_pkg::RAM_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // A count of zero wraps to an all-ones mask, as the bank hardware sees it.
    assign rom_count_m1 = rom_count_reg - cbc_pkg::ROM_CNT_W'(1);
    assign ram_count_m1 = ram_count_reg - cbc_pkg::RAM_CNT_W'(1);

    assign cfg_out.ctrl_type = ctrl_type_reg;
    assign cfg_out.rom_mask  = rom_count_m1[cbc_pkg::ROM_BANK_W-1:0];
    assign cfg_out.ram_mask  = ram_count_m1[cbc_pkg::RAM_BANK_W-1:0];

endmodule

>>> hdl/cbc_bank_ctl.sv
// Bank state registers and the decode of control writes for every controller type but CT_NONE.
module cbc_bank_ctl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  cbc_pkg::cfg_t        cfg,
    input  cbc_pkg::req_t        req,
    output cbc_pkg::bank_state_t st_next,
    output logic                 strobe
);

    cbc_pkg::bank_state_t            st_reg;
    logic                            rom_we;
    logic                            ram_we;
    logic                            en_we;
    logic [cbc_pkg::ROM_BANK_W-1:0]  rom_v;
    logic [cbc_pkg::RAM_BANK_W-1:0]  ram_v;
    logic [1:0]                      rgn;
    logic [2:0]                      nib;
    logic [cbc_pkg::DATA_W-1:0]      b;
    logic [4:0]                      lo5;
    logic [3:0]                      lo4;
    logic [6:0]                      lo7;

    assign b   = req.write_data;
    assign rgn = req.bus_address[14:13];
    assign nib = req.bus_address[14:12];
    // A low bank field written as zero selects bank one.
    assign lo5 = (b[4:0] == 5'd0) ? 5'd1 : b[4:0];
    assign lo4 = (b[3:0] == 4'd0) ? 4'd1 : b[3:0];
    assign lo7 = (b[6:0] == 7'd0) ? 7'd1 : b[6:0];

    always_comb
    begin
        rom_we  = 1'b0;
        ram_we  = 1'b0;
        en_we   = 1'b0;
        rom_v   = st_reg.rom_bank;
        ram_v   = st_reg.ram_bank;
        strobe  = 1'b0;
        st_next = st_reg;
        if (req.mode && !req.bus_address[15])
        begin
            case (cfg.ctrl_type) inside
                cbc_pkg::CT_MBC1, cbc_pkg::CT_HUC1:
                begin
                    unique case (rgn)
                        cbc_pkg::RGN_ENABLE: en_we = 1'b1;
                        cbc_pkg::RGN_ROM:
                        begin
                            rom_we = 1'b1;
                            rom_v  = {2'b00, st_reg.rom_bank[6:5], lo5};
                        end
                        cbc_pkg::RGN_UPPER:
                        begin
                            if (st_reg.banking_mode)
                            begin
                                ram_we = 1'b1;
                                ram_v  = {2'b00, b[1:0]};
                            end
                            else
                            begin
                                rom_we = 1'b1;
                                rom_v  = {2'b00, b[1:0], st_reg.rom_bank[4:0]};
                            end
                        end
                        default: st_next.banking_mode = b[0];
                    endcase
                end
                cbc_pkg::CT_MBC2:
                begin
                    if (!req.bus_address[14])
                    begin
                        if (!req.bus_address[8])
                            en_we = 1'b1;
                        else
                        begin
                            rom_we = 1'b1;
                            rom_v  = {5'd0, lo4};
                        end
                    end
                end
                cbc_pkg::CT_MBC3, cbc_pkg::CT_HUC3:
                begin
                    unique case (rgn)
                        cbc_pkg::RGN_ENABLE: en_we = 1'b1;
                        cbc_pkg::RGN_ROM:
                        begin
                            rom_we = 1'b1;
                            rom_v  = {2'b00, lo7};
                        end
                        cbc_pkg::RGN_UPPER:
                        begin
                            st_next.rtc_select = b[3:0];
                            ram_we = 1'b1;
                            ram_v  = {2'b00, b[1:0]};
                        end
                        default: strobe = 1'b1;
                    endcase
                end
                cbc_pkg::CT_MBC5, cbc_pkg::CT_MBC5_R:
                begin
                    case (nib) inside
                        cbc_pkg::M5_EN_A, cbc_pkg::M5_EN_B: en_we = 1'b1;
                        cbc_pkg::M5_ROM_LO:
                        begin
                            rom_we = 1'b1;
                            rom_v  = {st_reg.rom_bank[8], b};
                        end
                        cbc_pkg::M5_ROM_HI:
                        begin
                            rom_we = 1'b1;
                            rom_v  = {b[0], st_reg.rom_bank[7:0]};
                        end
                        cbc_pkg::M5_RAM_A, cbc_pkg::M5_RAM_B:
                        begin
                            ram_we = 1'b1;
                            // The rumble variant uses bit 3 for the motor.
                            ram_v  = (cfg.ctrl_type == cbc_pkg::CT_MBC5_R) ?
                                     {1'b0, b[2:0]} : b[3:0];
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        if (rom_we)
            st_next.rom_bank = rom_v & cfg.rom_mask;
        if (ram_we)
            st_next.ram_bank = ram_v & cfg.ram_mask;
        if (en_we)
            st_next.ram_enable = (b[3:0] == cbc_pkg::RAM_EN_KEY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.rom_bank     <= cbc_pkg::ROM_BANK_RESET;
            st_reg.ram_bank     <= '0;
            st_reg.ram_enable   <= 1'b0;
            st_reg.banking_mode <= 1'b0;
            st_reg.rtc_select   <= '0;
        end
        else if (en)
            st_reg <= st_next;
    end

endmodule

>>> hdl/cbc_xlate.sv
// Address translation of one access into a ROM, save RAM, RTC, fixed-value, absorbed or empty result.
module cbc_xlate (
    input  cbc_pkg::req_t                  req,
    input  cbc_pkg::bank_state_t           st,
    input  logic [cbc_pkg::CTYPE_W-1:0]    ctrl_type,
    input  logic                           strobe,
    output cbc_pkg::res_t                  res
);

    localparam int ROM_PAD = cbc_pkg::PHYS_W - cbc_pkg::ADDR_W;
    localparam int RAM_PAD = cbc_pkg::PHYS_W - cbc_pkg::RAM_BANK_W - cbc_pkg::RAM_OFS_W;

    logic [cbc_pkg::ADDR_W-1:0] a;

    assign a = req.bus_address;

    always_comb
    begin
        res.target           = cbc_pkg::TGT_NONE;
        res.physical_address = '0;
        res.rtc_index        = '0;
        res.fixed_value      = '0;
        res.rom_bank_now     = st.rom_bank;
        res.ram_bank_now     = st.ram_bank;
        res.ram_enabled_now  = st.ram_enable;
        res.rtc_select_now   = st.rtc_select;
        res.latch_strobe     = strobe;
        res.latch_data       = strobe ? req.write_data : '0;
        if (!a[15])
        begin
            if (req.mode)
                res.target = cbc_pkg::TGT_ABSORB;
            else
            begin
                res.target = cbc_pkg::TGT_ROM;
                if (!a[14])
                    res.physical_address = {{ROM_PAD{1'b0}}, a};
                else
                    res.physical_address = {st.rom_bank, a[cbc_pkg::ROM_OFS_W-1:0]};
            end
        end
        else if (a[15:13] == cbc_pkg::RAM_WINDOW)
        begin
            // The bank state is unchanged by window accesses, so st holds the live values.
            if (!st.ram_enable)
            begin
                if (req.mode)
                    res.target = cbc_pkg::TGT_ABSORB;
                else
                begin
                    res.target      = cbc_pkg::TGT_FIXED;
                    res.fixed_value = (ctrl_type == cbc_pkg::CT_HUC3) ?
                                      cbc_pkg::FIXED_HUC3 : cbc_pkg::FIXED_OPEN;
                end
            end
            else if (st.rtc_select[3])
            begin
                res.target    = cbc_pkg::TGT_RTC;
                res.rtc_index = st.rtc_select[2:0];
            end
            else
            begin
                res.target           = cbc_pkg::TGT_RAM;
                res.physical_address = {{RAM_PAD{1'b0}}, st.ram_bank,
                                        a[cbc_pkg::RAM_OFS_W-1:0]};
            end
        end
    end

endmodule

>>> hdl/cartridge_bank_controller.sv
// Top level of the cartridge bank controller: input register, decode and result register.
//
//   Channel | Direction | Carries
//   acc     | in        | mode, bus_address, write_data
//   res     | out       | target, physical_address, rtc_index, fixed_value, bank state, latch
//   cfg     | in        | index, data (controller type, ROM bank count, RAM bank count)
//
// One access per cycle while res is not stalled: a transfer on acc is registered in the
// input register, decoded from there and lands in the result register.
// The bank state is updated as an access moves into the result register, so each
// access sees the state left by the one before it.
// A stalled result holds the result register; the input register still takes one more
// access before acc.ready drops. Reset restores the bank state, configuration and valid flags.
module cartridge_bank_controller (
    input  logic            clk,
    input  logic            rst_n,
    cbc_access_if.sink      acc,
    cbc_result_if.source    res,
    cbc_cfg_if.sink         cfg
);

    logic                   in_vld_reg;
    cbc_pkg::req_t          in_req_reg;
    logic                   out_vld_reg;
    cbc_pkg::res_t          out_res_reg;
    logic                   out_free;
    logic                   adv;
    cbc_pkg::cfg_t          cfg_cur;
    cbc_pkg::bank_state_t   st_next;
    logic                   strobe;
    cbc_pkg::res_t          res_next;

    assign out_free  = !out_vld_reg || res.ready;
    assign adv       = in_vld_reg && out_free;
    assign acc.ready = !in_vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (acc.ready)
                in_vld_reg <= acc.valid;
            if (out_free)
                out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc.valid && acc.ready)
        begin
            in_req_reg.mode        <= acc.mode;
            in_req_reg.bus_address <= acc.bus_address;
            in_req_reg.write_data  <= acc.write_data;
        end
        if (adv)
            out_res_reg <= res_next;
    end

    cbc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    cbc_bank_ctl u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .cfg     (cfg_cur),
        .req     (in_req_reg),
        .st_next (st_next),
        .strobe  (strobe)
    );

    cbc_xlate u_xlate (
        .req       (in_req_reg),
        .st        (st_next),
        .ctrl_type (cfg_cur.ctrl_type),
        .strobe    (strobe),
        .res       (res_next)
    );

    assign res.valid            = out_vld_reg;
    assign res.target           = out_res_reg.target;
    assign res.physical_address = out_res_reg.physical_address;
    assign res.rtc_index        = out_res_reg.rtc_index;
    assign res.fixed_value      = out_res_reg.fixed_value;
    assign res.rom_bank_now     = out_res_reg.rom_bank_now;
    assign res.ram_bank_now     = out_res_reg.ram_bank_now;
    assign res.ram_enabled_now  = out_res_reg.ram_enabled_now;
    assign res.rtc_select_now   = out_res_reg.rtc_select_now;
    assign res.latch_strobe     = out_res_reg.latch_strobe;
    assign res.latch_data       = out_res_reg.latch_data;

endmodule

>>> hdl/cbc_checker.sv
// Port-level checker of the cartridge bank controller and its bind to the top level.
`include "cartridge_bank_controller_macros.svh"

module cbc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [cbc_pkg::TGT_W-1:0]       target,
    input logic [cbc_pkg::PHYS_W-1:0]      physical_address,
    input logic [cbc_pkg::RTC_IDX_W-1:0]   rtc_index,
    input logic [cbc_pkg::DATA_W-1:0]      fixed_value,
    input logic                            ram_enabled_now,
    input logic [cbc_pkg::RTC_SEL_W-1:0]   rtc_select_now,
    input logic                            latch_strobe
);

    `CBC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(target) && $stable(physical_address), "stalled result changed before its transfer")

    `CBC_ASSERT_SAME(a_rtc_sel, res_valid && target == cbc_pkg::TGT_RTC, rtc_select_now[3] && ram_enabled_now && rtc_index == rtc_select_now[2:0], "RTC result does not match the RTC select")

    `CBC_ASSERT_SAME(a_latch_abs, res_valid && latch_strobe, target == cbc_pkg::TGT_ABSORB, "latch strobe on an access that is not a control write")

    `CBC_ASSERT_SAME(a_fixed, res_valid && target == cbc_pkg::TGT_FIXED, !ram_enabled_now && physical_address == '0 && (fixed_value == cbc_pkg::FIXED_OPEN || fixed_value == cbc_pkg::FIXED_HUC3), "fixed value returned with RAM enabled or with a bad value")

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .target           (res.target),
    .physical_address (res.physical_address),
    .rtc_index        (res.rtc_index),
    .fixed_value      (res.fixed_value),
    .ram_enabled_now  (res.ram_enabled_now),
    .rtc_select_now   (res.rtc_select_now),
    .latch_strobe     (res.latch_strobe)
);
